// File: sv/lsd_pkg.sv
// Package: shared constants and types for the latency spike detector.
`timescale 1ns / 1ps
package lsd_pkg;
   localparam int CHANNELS_DEF  = 16;
   localparam int FRAC_BITS_DEF = 8;
   localparam int LAT_W   = 20;
   localparam int CNT_W   = 24;
   localparam int SPK_W   = 16;
   localparam int M2_W    = 64;
   localparam int OUT_MEAN_W = 28;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DAT_W  = 20;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_BASELINE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_LIMIT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIGMA        = 2'd3;

   localparam logic [7:0]        MIN_BASELINE_RST = 8'd5;
   localparam logic [LAT_W-1:0]  FLOOR_RST        = 20'd80;
   localparam logic [LAT_W-1:0]  HARD_LIMIT_RST   = 20'd200;
   localparam logic [3:0]        SIGMA_RST        = 4'd2;

   localparam logic [SPK_W-1:0]  WARN_A = 16'd5;
   localparam logic [SPK_W-1:0]  WARN_B = 16'd15;
   localparam logic [SPK_W-1:0]  WARN_C = 16'd30;

   typedef struct packed {
      logic [7:0]       min_baseline;
      logic [LAT_W-1:0] floor_ms;
      logic [LAT_W-1:0] hard_limit_ms;
      logic [3:0]       sigma;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_DIV, ST_MEAN, ST_PROD, ST_ACC,
      ST_LHS, ST_RHS, ST_CMP, ST_OUT
   } state_type;
endpackage

// File: sv/lsd_front.sv
// Front end: accepts beats, folds the channel index, two-entry queue to the engine.
`timescale 1ns / 1ps
module lsd_front #(
   parameter int CHANNELS = lsd_pkg::CHANNELS_DEF,
   parameter int CH_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [3:0]                req_channel_index,
   input  logic [lsd_pkg::LAT_W-1:0] req_latency_ms,
   output logic                      q_valid,
   input  logic                      q_pop,
   output logic [CH_W-1:0]           q_ch,
   output logic [lsd_pkg::LAT_W-1:0] q_lat
);
   localparam int W = CH_W + lsd_pkg::LAT_W;
   logic [W-1:0] mem_ff [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         rd_ff, rd_in, wr_ff, wr_in;
   logic         push;
   logic [CH_W-1:0] ch_fold;

   // Index folds onto the channel range through a small constant table.
   always_comb begin
      ch_fold = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_channel_index == 4'(i)) ch_fold = CH_W'(i % CHANNELS);
      end
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall;
   assign q_valid   = cnt_ff != 2'd0;
   assign {q_ch, q_lat} = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
      rd_in  = rd_ff ^ q_pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) mem_ff[wr_ff] <= {ch_fold, req_latency_ms};
   end
endmodule

// File: sv/lsd_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lsd_divider #(
   parameter int N_W = 28,
   parameter int D_W = 24
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] numer,
   input  logic [D_W-1:0] denom,
   output logic           done,
   output logic [N_W-1:0] quot
);
   localparam int CW = $clog2(N_W + 1);
   logic [N_W-1:0] q_ff, q_in;
   logic [D_W:0]   r_ff, r_in;
   logic [D_W-1:0] d_ff, d_in;
   logic [CW-1:0]  c_ff, c_in;
   logic           busy_ff, busy_in;
   logic [D_W:0]   trial;

   assign quot = q_ff;
   assign done = busy_ff && c_ff == CW'(0);

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; c_in = c_ff; busy_in = busy_ff;
      trial = {r_ff[D_W-1:0], q_ff[N_W-1]};
      if (start) begin
         q_in = numer; r_in = '0; d_in = denom; c_in = CW'(N_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (c_ff == CW'(0)) begin
            busy_in = 1'b0;
         end else begin
            c_in = c_ff - CW'(1);
            if (trial >= {1'b0, d_ff}) begin
               r_in = trial - {1'b0, d_ff};
               q_in = {q_ff[N_W-2:0], 1'b1};
            end else begin
               r_in = trial;
               q_in = {q_ff[N_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; c_ff <= c_in;
   end
endmodule

// File: sv/lsd_engine.sv
// Back end: per-channel statistics update and spike classification.
`timescale 1ns / 1ps
module lsd_engine #(
   parameter int CH_W = 4,
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lsd_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic [CH_W-1:0]             q_ch,
   input  logic [lsd_pkg::LAT_W-1:0]   q_lat,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_spike,
   output logic                        rsp_channel_warning,
   output logic [lsd_pkg::SPK_W-1:0]   rsp_spike_count,
   output logic [lsd_pkg::OUT_MEAN_W-1:0] rsp_mean_q8,
   output logic [lsd_pkg::CNT_W-1:0]   rsp_samples_seen
);
   localparam int CHN = 1 << CH_W;
   localparam int MW  = lsd_pkg::LAT_W + FRAC_BITS;
   localparam int CW  = lsd_pkg::CNT_W;
   localparam int M2W = lsd_pkg::M2_W;
   localparam int DNW = MW + CW;
   localparam int DLO = DNW / 2;
   localparam logic [CW-1:0] CNT_MAX = '1;
   localparam logic [lsd_pkg::SPK_W-1:0] SPK_MAX = '1;

   // Stores; entry valid bits stand in for clearing at reset.
   logic [CHN-1:0]  vld_ff;
   logic [CW-1:0]   cnt_mem [CHN];
   logic [MW-1:0]   mean_mem [CHN];
   logic [M2W-1:0]  m2_mem [CHN];
   logic [lsd_pkg::SPK_W-1:0] spk_mem [CHN];

   lsd_pkg::state_type st_ff, st_in;
   logic [CH_W-1:0] ch_ff;
   logic [lsd_pkg::LAT_W-1:0] lat_ff;
   logic [MW-1:0]   L_ff, m_ff, mnew_ff, a_ff, b_ff;
   logic [CW-1:0]   n_ff;
   logic [M2W-1:0]  m2_ff;
   logic [lsd_pkg::SPK_W-1:0] sc_ff;
   logic            ge_ff;
   logic [127:0]    prod_ff, lhs_ff, rhs_ff;
   logic [DNW-1:0]  dn_ff;
   logic            spike_ff, warn_ff, ov_ff, rv_ff;

   logic            div_start, div_done;
   logic [MW-1:0]   div_q;
   logic [MW-1:0]   mnew_c, d_c, a_c;
   logic [CW-1:0]   n_c;
   logic [M2W:0]    sum_c;
   logic [7:0]      k2;
   logic            stat_c, spike_c, out_fire;
   logic [lsd_pkg::SPK_W-1:0] sc_c;

   lsd_divider #(.N_W(MW), .D_W(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(a_c),
      .denom(n_c), .done(div_done), .quot(div_q)
   );

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         lsd_pkg::ST_IDLE: if (q_valid) st_in = lsd_pkg::ST_READ;
         lsd_pkg::ST_READ: st_in = lsd_pkg::ST_DIV;
         lsd_pkg::ST_DIV:  if (div_done) st_in = lsd_pkg::ST_MEAN;
         lsd_pkg::ST_MEAN: st_in = lsd_pkg::ST_PROD;
         lsd_pkg::ST_PROD: st_in = lsd_pkg::ST_ACC;
         lsd_pkg::ST_ACC:  st_in = lsd_pkg::ST_LHS;
         lsd_pkg::ST_LHS:  st_in = lsd_pkg::ST_RHS;
         lsd_pkg::ST_RHS:  st_in = lsd_pkg::ST_CMP;
         lsd_pkg::ST_CMP:  st_in = lsd_pkg::ST_OUT;
         lsd_pkg::ST_OUT:  if (!ov_ff) st_in = lsd_pkg::ST_IDLE;
         default:          st_in = lsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = st_ff == lsd_pkg::ST_IDLE && q_valid;
      div_start = st_ff == lsd_pkg::ST_READ;
      busy      = st_ff != lsd_pkg::ST_IDLE;
      // divider operands: |L - m| and the bumped count
      a_c       = (L_ff >= m_ff) ? L_ff - m_ff : m_ff - L_ff;
      n_c       = (n_ff != CNT_MAX) ? n_ff + 1'b1 : n_ff;
      k2        = 8'(cfg.sigma) * 8'(cfg.sigma);
      mnew_c    = ge_ff ? m_ff + div_q : m_ff - div_q;
      d_c       = L_ff - mnew_ff;
      sum_c     = {1'b0, m2_ff} + {1'b0, prod_ff[63:0]};
      stat_c    = (n_ff >= CW'(cfg.min_baseline)) && (lat_ff > cfg.floor_ms) &&
                  (L_ff > mnew_ff) && ((n_ff <= CW'(1)) || (lhs_ff > rhs_ff));
      spike_c   = stat_c || (lat_ff >= cfg.hard_limit_ms);
      sc_c      = (spike_c && sc_ff != SPK_MAX) ? sc_ff + 1'b1 : sc_ff;
      out_fire  = st_ff == lsd_pkg::ST_OUT && ov_ff && (!rv_ff || !rsp_stall);
   end

   assign rsp_valid = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= lsd_pkg::ST_IDLE;
         vld_ff <= '0;
         rv_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= out_fire || (rv_ff && rsp_stall);
         if (st_ff == lsd_pkg::ST_CMP) begin
            ov_ff <= 1'b1;
            vld_ff[ch_ff] <= 1'b1;
         end
         if (out_fire) ov_ff <= 1'b0;
      end
      case (st_ff)
         lsd_pkg::ST_IDLE: begin
            ch_ff  <= q_ch;
            lat_ff <= q_lat;
            L_ff   <= {q_lat, FRAC_BITS'(0)};
            n_ff   <= vld_ff[q_ch] ? cnt_mem[q_ch] : '0;
            m_ff   <= vld_ff[q_ch] ? mean_mem[q_ch] : '0;
            m2_ff  <= vld_ff[q_ch] ? m2_mem[q_ch] : '0;
            sc_ff  <= vld_ff[q_ch] ? spk_mem[q_ch] : '0;
         end
         lsd_pkg::ST_READ: begin
            n_ff  <= n_c;
            ge_ff <= L_ff >= m_ff;
            a_ff  <= a_c;
         end
         lsd_pkg::ST_DIV: if (div_done) begin
            mnew_ff <= mnew_c;
         end
         lsd_pkg::ST_MEAN: b_ff <= ge_ff ? L_ff - mnew_ff : mnew_ff - L_ff;
         lsd_pkg::ST_PROD: prod_ff <= 128'(a_ff) * 128'(b_ff);
         lsd_pkg::ST_ACC: begin
            // a product past 64 bits pins the sum as well
            m2_ff <= (sum_c[M2W] || prod_ff[127:64] != '0) ? '1 : sum_c[M2W-1:0];
            dn_ff <= DNW'(d_c) * DNW'(n_ff - CW'(1));
         end
         // d*(n-1)*d in two halves to keep each multiply narrow
         lsd_pkg::ST_LHS: lhs_ff <= 128'(dn_ff[DLO-1:0]) * 128'(d_c);
         lsd_pkg::ST_RHS: begin
            rhs_ff <= 128'(m2_ff) * 128'(k2);
            lhs_ff <= lhs_ff + ((128'(dn_ff[DNW-1:DLO]) * 128'(d_c)) << DLO);
         end
         lsd_pkg::ST_CMP: begin
            spike_ff <= spike_c;
            warn_ff  <= spike_c && (sc_c == lsd_pkg::WARN_A || sc_c == lsd_pkg::WARN_B ||
                                    sc_c == lsd_pkg::WARN_C);
            sc_ff    <= sc_c;
            cnt_mem[ch_ff]  <= n_ff;
            mean_mem[ch_ff] <= mnew_ff;
            m2_mem[ch_ff]   <= m2_ff;
            spk_mem[ch_ff]  <= sc_c;
         end
         default: ;
      endcase
      if (out_fire) begin
         rsp_spike           <= spike_ff;
         rsp_channel_warning <= warn_ff;
         rsp_spike_count     <= sc_ff;
         rsp_mean_q8         <= lsd_pkg::OUT_MEAN_W'(mnew_ff);
         rsp_samples_seen    <= n_ff;
      end
   end
endmodule

// File: sv/latency_spike_detector_unit.sv
// Top level: latency spike detector with per-channel running statistics.
`timescale 1ns / 1ps
// Usage:
//  - req_ channel: one beat per completed read (channel index, latency in ms),
//    taken when req_valid is high and req_stall low. A two-beat queue sits
//    in front of the statistics engine.
//  - rsp_ channel: one beat per request, in order, carrying spike flag, warning,
//    spike count, updated mean and sample count. Held while rsp_stall is high.
//  - csr_ channel: register writes (index, data) taken on csr_valid & csr_ready;
//    ready only while the queue, engine and output are empty. Index 0
//    min_baseline, 1 floor_ms, 2 hard_limit_ms, 3 sigma_multiplier.
//  - Processing: the restoring mean divider takes one quotient bit per cycle
//    over the 20+FRAC_BITS bit mean, followed by the registered multiply and
//    compare steps. The engine serves one read at a time and pops no new beat
//    from the queue until the result of the last one is in the output register.
//  - Reset (synchronous): all per-channel stats read as zero, registers back
//    to their defaults, queue and output empty.
//  - A stalled result beat holds; the engine waits on it and the queue
//    then fills, raising req_stall.
module latency_spike_detector_unit #(
   parameter int CHANNELS  = lsd_pkg::CHANNELS_DEF,
   parameter int FRAC_BITS = lsd_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [3:0]                       req_channel_index,
   input  logic [lsd_pkg::LAT_W-1:0]        req_latency_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_spike,
   output logic                             rsp_channel_warning,
   output logic [lsd_pkg::SPK_W-1:0]        rsp_spike_count,
   output logic [lsd_pkg::OUT_MEAN_W-1:0]   rsp_mean_q8,
   output logic [lsd_pkg::CNT_W-1:0]        rsp_samples_seen,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsd_pkg::CSR_DAT_W-1:0]    csr_data
);
   // Channel index bits; the front end folds the index onto CHANNELS.
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   lsd_pkg::cfg_type cfg_ff;
   logic q_valid, q_pop, busy;
   logic [CH_W-1:0] q_ch;
   logic [lsd_pkg::LAT_W-1:0] q_lat;

   assign csr_ready = !busy && !q_valid && !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_baseline  <= lsd_pkg::MIN_BASELINE_RST;
         cfg_ff.floor_ms      <= lsd_pkg::FLOOR_RST;
         cfg_ff.hard_limit_ms <= lsd_pkg::HARD_LIMIT_RST;
         cfg_ff.sigma         <= lsd_pkg::SIGMA_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lsd_pkg::REG_MIN_BASELINE: cfg_ff.min_baseline  <= csr_data[7:0];
            lsd_pkg::REG_FLOOR:        cfg_ff.floor_ms      <= csr_data;
            lsd_pkg::REG_HARD_LIMIT:   cfg_ff.hard_limit_ms <= csr_data;
            lsd_pkg::REG_SIGMA:        cfg_ff.sigma         <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   lsd_front #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_channel_index(req_channel_index), .req_latency_ms(req_latency_ms),
      .q_valid(q_valid), .q_pop(q_pop), .q_ch(q_ch), .q_lat(q_lat)
   );

   lsd_engine #(.CH_W(CH_W), .FRAC_BITS(FRAC_BITS)) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid), .q_pop(q_pop),
      .q_ch(q_ch), .q_lat(q_lat), .busy(busy), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_spike(rsp_spike),
      .rsp_channel_warning(rsp_channel_warning), .rsp_spike_count(rsp_spike_count),
      .rsp_mean_q8(rsp_mean_q8), .rsp_samples_seen(rsp_samples_seen)
   );
endmodule

// File: tb/latency_spike_detector_unit_tb.sv
// Testbench: latency spike detector, self-checking against a built-in statistics predictor.
`timescale 1ns / 1ps
module latency_spike_detector_unit_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 60;

   // result beat as predicted
   typedef struct {
      logic                           spike;
      logic                           warning;
      logic [lsd_pkg::SPK_W-1:0]      spike_count;
      logic [lsd_pkg::OUT_MEAN_W-1:0] mean_q8;
      logic [lsd_pkg::CNT_W-1:0]      samples_seen;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_channel_index = '0;
   logic [lsd_pkg::LAT_W-1:0] req_latency_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_spike, rsp_channel_warning;
   logic [lsd_pkg::SPK_W-1:0] rsp_spike_count;
   logic [lsd_pkg::OUT_MEAN_W-1:0] rsp_mean_q8;
   logic [lsd_pkg::CNT_W-1:0] rsp_samples_seen;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lsd_pkg::CSR_IDX_W-1:0] csr_index = lsd_pkg::REG_MIN_BASELINE;
   logic [lsd_pkg::CSR_DAT_W-1:0] csr_data = '0;

   latency_spike_detector_unit DUT (.*);

   // predictor state, mirrors the per-channel stores
   lsd_pkg::cfg_type cfg;
   logic [lsd_pkg::CNT_W-1:0]  stat_count [16];
   logic [27:0]                stat_mean  [16];
   logic [63:0]                stat_m2    [16];
   logic [lsd_pkg::SPK_W-1:0]  stat_spikes[16];
   verdict_type pending_verdicts[$];

   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int spikes_seen = 0;
   int warnings_seen = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_rsp = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("MISMATCH beat %0d %s: got %0h expected %0h", beats_checked, what, got, want);
   endtask

   task automatic clear_stats();
      for (int c = 0; c < 16; c++) begin
         stat_count[c] = '0;
         stat_mean[c] = '0;
         stat_m2[c] = '0;
         stat_spikes[c] = '0;
      end
      cfg.min_baseline = lsd_pkg::MIN_BASELINE_RST;
      cfg.floor_ms = lsd_pkg::FLOOR_RST;
      cfg.hard_limit_ms = lsd_pkg::HARD_LIMIT_RST;
      cfg.sigma = lsd_pkg::SIGMA_RST;
   endtask

   // Welford update plus the root-free sigma test
   function automatic verdict_type classify_read(input logic [3:0] ch,
                                                 input logic [lsd_pkg::LAT_W-1:0] lat);
      verdict_type v;
      logic [lsd_pkg::CNT_W-1:0] n;
      logic [63:0] lq, m, a, b, mnew, stepv, m2, d;
      logic [127:0] prod, lhs, rhs;
      logic is_stat;
      n = stat_count[ch];
      m = {36'd0, stat_mean[ch]};
      m2 = stat_m2[ch];
      lq = {44'd0, lat} << lsd_pkg::FRAC_BITS_DEF;
      if (n != '1) n = n + 1'b1;
      if (lq >= m) begin
         a = lq - m;
         stepv = a / n;
         mnew = m + stepv;
         b = lq - mnew;
      end else begin
         a = m - lq;
         stepv = a / n;
         mnew = m - stepv;
         b = mnew - lq;
      end
      mnew = mnew & 64'hFFF_FFFF;
      prod = {64'd0, a} * {64'd0, b};
      if (prod[127:64] != 0) prod[63:0] = '1;
      m2 = (m2 > ~prod[63:0]) ? '1 : m2 + prod[63:0];
      is_stat = 1'b0;
      if (n >= cfg.min_baseline && lat > cfg.floor_ms && lq > mnew) begin
         d = lq - mnew;
         if (n <= 1) is_stat = 1'b1;
         else begin
            // the left factor wraps at 64 bits before the second multiply
            lhs = {64'd0, d * (64'(n) - 64'd1)} * {64'd0, d};
            rhs = {64'd0, m2} * (128'(cfg.sigma) * 128'(cfg.sigma));
            is_stat = lhs > rhs;
         end
      end
      v.spike = is_stat || lat >= cfg.hard_limit_ms;
      v.warning = 1'b0;
      if (v.spike) begin
         if (stat_spikes[ch] != '1) stat_spikes[ch] = stat_spikes[ch] + 1'b1;
         v.warning = stat_spikes[ch] == lsd_pkg::WARN_A ||
                     stat_spikes[ch] == lsd_pkg::WARN_B ||
                     stat_spikes[ch] == lsd_pkg::WARN_C;
      end
      stat_count[ch] = n;
      stat_mean[ch] = mnew[27:0];
      stat_m2[ch] = m2;
      v.spike_count = stat_spikes[ch];
      v.mean_q8 = mnew[27:0];
      v.samples_seen = n;
      return v;
   endfunction

   // one request beat; prediction made at acceptance; valid drops on idle or drain
   task automatic send_read(input logic [3:0] ch, input logic [lsd_pkg::LAT_W-1:0] lat);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel_index <= ch;
      req_latency_ms <= lat;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(classify_read(ch, lat));
      beats_sent++;
   endtask

   // receiver stall pattern, plus a long hold when asked
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct;
   end

   // checks every accepted result beat against the oldest prediction
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_spike !== want.spike) report_mismatch("spike", rsp_spike, want.spike);
            if (rsp_channel_warning !== want.warning)
               report_mismatch("warning", rsp_channel_warning, want.warning);
            if (rsp_spike_count !== want.spike_count)
               report_mismatch("spike_count", rsp_spike_count, want.spike_count);
            if (rsp_mean_q8 !== want.mean_q8)
               report_mismatch("mean_q8", rsp_mean_q8, want.mean_q8);
            if (rsp_samples_seen !== want.samples_seen)
               report_mismatch("samples_seen", rsp_samples_seen, want.samples_seen);
            if (want.spike) spikes_seen++;
            if (want.warning) warnings_seen++;
         end
         beats_checked++;
      end
   end

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only with the block idle; caller drops csr_valid
   task automatic write_reg(input logic [lsd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lsd_pkg::CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lsd_pkg::REG_MIN_BASELINE: cfg.min_baseline = val[7:0];
         lsd_pkg::REG_FLOOR:        cfg.floor_ms = val;
         lsd_pkg::REG_HARD_LIMIT:   cfg.hard_limit_ms = val;
         lsd_pkg::REG_SIGMA:        cfg.sigma = val[3:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] mb, input logic [lsd_pkg::LAT_W-1:0] fl,
                             input logic [lsd_pkg::LAT_W-1:0] hl, input logic [3:0] k);
      drain();
      write_reg(lsd_pkg::REG_MIN_BASELINE, {12'd0, mb});
      write_reg(lsd_pkg::REG_FLOOR, fl);
      write_reg(lsd_pkg::REG_HARD_LIMIT, hl);
      write_reg(lsd_pkg::REG_SIGMA, {16'd0, k});
      csr_valid <= 1'b0;
   endtask

   // field extremes, the first sample, hard limit, mean moving down, warnings
   task automatic test_directed();
      send_read(4'd0, '0);
      send_read(4'd15, '1);
      send_read(4'd15, '1);
      send_read(4'd15, '0);
      send_read(4'd15, 20'h55555);
      send_read(4'd15, 20'hAAAAA);
      for (int i = 0; i < 6; i++) send_read(4'd1, 20'd50);
      send_read(4'd1, 20'd150);
      for (int i = 0; i < 6; i++) send_read(4'd2, 20'd250);
      send_read(4'd3, 20'd199);
      send_read(4'd3, 20'd200);
   endtask

   // baselines on a channel, then a jump; most random reads look like this
   task automatic test_baseline_bursts(input int reads);
      logic [3:0] ch;
      logic [lsd_pkg::LAT_W-1:0] base, lat;
      int sent;
      sent = 0;
      while (sent < reads) begin
         ch = 4'($urandom_range(15, 0));
         base = ($urandom_range(3, 0) == 0) ? lsd_pkg::LAT_W'($urandom()) :
                                              lsd_pkg::LAT_W'($urandom_range(150, 10));
         for (int i = $urandom_range(10, 2); i > 0 && sent < reads; i--) begin
            case ($urandom_range(9, 0))
               0: lat = lsd_pkg::LAT_W'($urandom());
               1: lat = lsd_pkg::LAT_W'(base * $urandom_range(6, 2));
               2: lat = '1;
               default: lat = lsd_pkg::LAT_W'(base + $urandom_range(8, 0) - 4);
            endcase
            send_read(ch, lat);
            sent++;
         end
      end
   endtask

   // receiver holds off long enough to back the queue up into req_stall
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            for (int c = 0; c < 400; c++) @(posedge clock);
            hold_rsp = 0;
         end
         test_baseline_bursts(8);
      join
   endtask

   initial begin
      clear_stats();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      set_config(8'd0, 20'd0, '1, 4'd0);
      test_directed();
      set_config(8'd255, '1, 20'd0, 4'd15);
      test_baseline_bursts(20);
      set_config(8'd3, 20'd40, 20'd500, 4'd1);

      send_idle_pct = 34;
      recv_idle_pct = 56;
      test_baseline_bursts(300);
      test_backpressure();
      set_config(lsd_pkg::MIN_BASELINE_RST, lsd_pkg::FLOOR_RST, lsd_pkg::HARD_LIMIT_RST,
                 lsd_pkg::SIGMA_RST);
      send_idle_pct = 56;
      recv_idle_pct = 34;
      test_baseline_bursts(300);
      set_config(8'd2, 20'd20, 20'd100000, 4'd3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_baseline_bursts(280);
      drain();

      $display("covered %0d reads, %0d checked; %0d spikes, %0d warnings, 5 register settings",
               beats_sent, beats_checked, spikes_seen, warnings_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end
endmodule
